FILE: rtl/core/ece_pkg.sv
// ece_pkg: shared types, fixed-point constants and pipeline latencies
// for the easing curve evaluator; no dependencies
package ece_pkg;

    localparam int FB  = 16;          // fraction bits of progress and result
    localparam int VW  = FB + 1;      // clamped value width, 0..ONE
    localparam int IW  = FB + 2;      // signed progress width
    localparam int EW  = FB + 4;      // exponent argument width, up to 10*ONE
    localparam int SH  = 30 - FB;     // shift from q30 to the value format
    localparam int NW  = EW - FB;     // integer part of exponent argument

    localparam logic [VW-1:0] ONE  = VW'(1) << FB;
    localparam logic [VW-1:0] HALF = VW'(1) << (FB - 1);
    localparam logic [30:0]   ONE30 = 31'h4000_0000;
    localparam logic [EW:0]   EXP_SPAN = (EW + 1)'(10) << FB;

    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // pipeline depths of the arithmetic units
    localparam int SIN_LAT  = 10;
    localparam int EXP_LAT  = 26;
    localparam int POLY_LAT = 3;

    typedef enum logic [3:0] {
        MODE_LINEAR      = 4'd0,
        MODE_SINE_IN     = 4'd1,
        MODE_SINE_OUT    = 4'd2,
        MODE_SINE_INOUT  = 4'd3,
        MODE_QUAD_IN     = 4'd4,
        MODE_QUAD_OUT    = 4'd5,
        MODE_QUAD_INOUT  = 4'd6,
        MODE_CUBIC_IN    = 4'd7,
        MODE_CUBIC_OUT   = 4'd8,
        MODE_CUBIC_INOUT = 4'd9,
        MODE_EXPO_IN     = 4'd10,
        MODE_EXPO_OUT    = 4'd11,
        MODE_EXPO_INOUT  = 4'd12
    } t_mode;

    // how the back end forms the result from its unit outputs
    typedef enum logic [4:0] {
        OP_LINEAR,
        OP_SIN,
        OP_SIN_INV,
        OP_SIN_LO,
        OP_SIN_HI,
        OP_SQ,
        OP_SQ_INV,
        OP_SQ2_LO,
        OP_SQ2_HI,
        OP_CUBE,
        OP_CUBE_INV,
        OP_CUBE4,
        OP_CUBE_HI,
        OP_EXP,
        OP_EXP_INV,
        OP_EXP_LO,
        OP_EXP_HI,
        OP_ZERO,
        OP_ONE
    } t_op;

    typedef struct packed {
        t_op           op;
        logic [VW-1:0] t;
        logic [VW-1:0] sin_x;
        logic [VW-1:0] poly_a;
        logic [EW-1:0] exp_a;
    } t_work;

    typedef struct packed {
        t_op           op;
        logic [VW-1:0] t;
    } t_tag;

endpackage

FILE: rtl/core/easing_curve_evaluator_top.sv
// easing_curve_evaluator_top: easing curve evaluator, top level
// uses ece_pkg, ece_front, ece_queue, ece_back
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+---------------------------
//  progress  | in        | push / full         | i_progress  (s2.16)
//  result    | out       | pop / empty         | o_eased_value (u1.16)
//  config    | in        | i_cfg_valid / ready | i_cfg_data  (curve select)
//
//  one item per clock sustained while the back end is not held; an item goes
//  through the work queue, the back-end pipeline (its depth set by the
//  exponent unit's 8 series terms of 3 stages each plus its argument and
//  shift stages) and the result register into the result queue
//  synchronous active-low reset empties both queues, drops all in-flight
//  work and sets the curve to linear
//  when the result queue is full and a result is done the whole back end
//  holds; the work queue keeps taking items until it fills, then full rises
module easing_curve_evaluator_top #(
    parameter int WORK_DEPTH = 4,
    parameter int RES_DEPTH  = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // progress in
    input  logic                   push,
    output logic                   full,
    input  logic [ece_pkg::IW-1:0] i_progress,
    // results out
    output logic                   empty,
    input  logic                   pop,
    output logic [ece_pkg::VW-1:0] o_eased_value,
    // curve select register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [3:0]             i_cfg_data
);

    localparam int WW = $bits(ece_pkg::t_work);

    logic [3:0]            r_ease_mode;
    ece_pkg::t_work        front_work;
    ece_pkg::t_work        head_work;
    logic [WW-1:0]         head_bits;
    logic                  work_empty, work_take;
    logic [ece_pkg::VW-1:0] back_res;
    logic                  res_push, res_full;

    // register always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ease_mode <= ece_pkg::MODE_LINEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ease_mode <= i_cfg_data;
        end
    end

    // front end: clamp and pick operands for the selected curve
    ece_front u_front (
        .i_progress (i_progress),
        .i_mode     (r_ease_mode),
        .o_work     (front_work)
    );

    // decouples the front end from back-end stalls
    ece_queue #(
        .DEPTH (WORK_DEPTH),
        .W     (WW)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (full),
        .i_pop   (work_take),
        .o_data  (head_bits),
        .o_empty (work_empty)
    );

    assign head_work = ece_pkg::t_work'(head_bits);

    ece_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (head_work),
        .i_work_valid (!work_empty),
        .o_work_take  (work_take),
        .o_res        (back_res),
        .o_res_push   (res_push),
        .i_res_full   (res_full)
    );

    // finished results wait here for the consumer
    ece_queue #(
        .DEPTH (RES_DEPTH),
        .W     (ece_pkg::VW)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_eased_value),
        .o_empty (empty)
    );

endmodule

FILE: rtl/core/ece_queue.sv
// ece_queue: small first-in first-out buffer in flip-flops
// no package dependencies
module ece_queue #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/ece_front.sv
// ece_front: clamps progress and classifies the item by curve into
// unit operands and a result op; uses ece_pkg
module ece_front (
    input  logic [ece_pkg::IW-1:0] i_progress,
    input  logic [3:0]             i_mode,
    output ece_pkg::t_work         o_work
);

    localparam int VW = ece_pkg::VW;
    localparam int EW = ece_pkg::EW;

    logic [VW-1:0] t, u;
    logic [VW:0]   two_t;
    logic [EW:0]   ten_t, ten_u, twenty_t;
    logic          t_zero, t_one, t_lo, t_le_half;

    always_comb begin
        if (i_progress[ece_pkg::IW-1]) begin
            t = '0;
        end else if (i_progress[VW-1:0] > ece_pkg::ONE) begin
            t = ece_pkg::ONE;
        end else begin
            t = i_progress[VW-1:0];
        end
        u         = ece_pkg::ONE - t;
        two_t     = {t, 1'b0};
        ten_t     = (EW + 1)'(t) * (EW + 1)'(10);
        ten_u     = (EW + 1)'(u) * (EW + 1)'(10);
        twenty_t  = (EW + 1)'(t) * (EW + 1)'(20);
        t_zero    = (t == '0);
        t_one     = (t == ece_pkg::ONE);
        t_lo      = (t < ece_pkg::HALF);
        t_le_half = (t <= ece_pkg::HALF);
    end

    always_comb begin
        o_work        = '0;
        o_work.t      = t;
        o_work.op     = ece_pkg::OP_LINEAR;
        case (i_mode)
            ece_pkg::MODE_SINE_IN: begin
                o_work.sin_x = u;
                o_work.op    = ece_pkg::OP_SIN_INV;
            end
            ece_pkg::MODE_SINE_OUT: begin
                o_work.sin_x = t;
                o_work.op    = ece_pkg::OP_SIN;
            end
            ece_pkg::MODE_SINE_INOUT: begin
                if (t_le_half) begin
                    o_work.sin_x = VW'({1'b0, ece_pkg::ONE} - two_t);
                    o_work.op    = ece_pkg::OP_SIN_LO;
                end else begin
                    o_work.sin_x = VW'(two_t - {1'b0, ece_pkg::ONE});
                    o_work.op    = ece_pkg::OP_SIN_HI;
                end
            end
            ece_pkg::MODE_QUAD_IN: begin
                o_work.poly_a = t;
                o_work.op     = ece_pkg::OP_SQ;
            end
            ece_pkg::MODE_QUAD_OUT: begin
                o_work.poly_a = u;
                o_work.op     = ece_pkg::OP_SQ_INV;
            end
            ece_pkg::MODE_QUAD_INOUT: begin
                if (t_lo) begin
                    o_work.poly_a = t;
                    o_work.op     = ece_pkg::OP_SQ2_LO;
                end else begin
                    o_work.poly_a = VW'({u, 1'b0});
                    o_work.op     = ece_pkg::OP_SQ2_HI;
                end
            end
            ece_pkg::MODE_CUBIC_IN: begin
                o_work.poly_a = t;
                o_work.op     = ece_pkg::OP_CUBE;
            end
            ece_pkg::MODE_CUBIC_OUT: begin
                o_work.poly_a = u;
                o_work.op     = ece_pkg::OP_CUBE_INV;
            end
            ece_pkg::MODE_CUBIC_INOUT: begin
                if (t_lo) begin
                    o_work.poly_a = t;
                    o_work.op     = ece_pkg::OP_CUBE4;
                end else begin
                    o_work.poly_a = VW'({u, 1'b0});
                    o_work.op     = ece_pkg::OP_CUBE_HI;
                end
            end
            ece_pkg::MODE_EXPO_IN: begin
                o_work.exp_a = EW'(ten_u);
                o_work.op    = t_zero ? ece_pkg::OP_ZERO : ece_pkg::OP_EXP;
            end
            ece_pkg::MODE_EXPO_OUT: begin
                o_work.exp_a = EW'(ten_t);
                o_work.op    = t_one ? ece_pkg::OP_ONE : ece_pkg::OP_EXP_INV;
            end
            ece_pkg::MODE_EXPO_INOUT: begin
                if (t_zero) begin
                    o_work.op = ece_pkg::OP_ZERO;
                end else if (t_one) begin
                    o_work.op = ece_pkg::OP_ONE;
                end else if (t_lo) begin
                    o_work.exp_a = EW'(ece_pkg::EXP_SPAN - twenty_t);
                    o_work.op    = ece_pkg::OP_EXP_LO;
                end else begin
                    o_work.exp_a = EW'(twenty_t - ece_pkg::EXP_SPAN);
                    o_work.op    = ece_pkg::OP_EXP_HI;
                end
            end
            default: begin
                o_work.op = ece_pkg::OP_LINEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/ece_sine.sv
// ece_sine: pipelined sin(pi/2 * x) in q30, odd series in horner form
// uses ece_pkg constants
module ece_sine (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ece_pkg::VW-1:0] i_x,
    output logic [30:0]            o_s
);

    localparam int VW = ece_pkg::VW;
    localparam logic [30:0] COEF [4] = '{ece_pkg::SIN_C7, ece_pkg::SIN_C5,
                                         ece_pkg::SIN_C3, ece_pkg::SIN_C1};

    logic [VW-1:0] r_x0;
    logic [30:0]   r_x20;
    logic [VW-1:0] r_xa [4], r_xb [4];
    logic [30:0]   r_x2a [4], r_x2b [4], r_prod [4], r_p [4];
    logic [30:0]   r_fp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0  <= i_x;
            r_x20 <= 31'((2 * VW)'(i_x) * (2 * VW)'(i_x) >> (2 * ece_pkg::FB - 30));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_step
        logic [30:0] p_in, x2_in;
        logic [VW-1:0] x_in;
        if (g == 0) begin : g_first
            assign p_in  = ece_pkg::SIN_C9;
            assign x2_in = r_x20;
            assign x_in  = r_x0;
        end else begin : g_rest
            assign p_in  = r_p[g-1];
            assign x2_in = r_x2b[g-1];
            assign x_in  = r_xb[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[g] <= 31'((62'(x2_in) * 62'(p_in)) >> 30);
                r_x2a[g]  <= x2_in;
                r_xa[g]   <= x_in;
                r_p[g]    <= COEF[g] - r_prod[g];
                r_x2b[g]  <= r_x2a[g];
                r_xb[g]   <= r_xa[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fp <= 31'((62'({r_xb[3], ece_pkg::SH'(0)}) * 62'(r_p[3])) >> 30);
        end
    end

    assign o_s = (r_fp > ece_pkg::ONE30) ? ece_pkg::ONE30 : r_fp;

endmodule

FILE: rtl/core/ece_expo.sv
// ece_expo: pipelined 2^-a in q30, exp series on the fraction, then shift
// uses ece_pkg constants
module ece_expo (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ece_pkg::EW-1:0] i_a,
    output logic [30:0]            o_e
);

    localparam int FB = ece_pkg::FB;
    localparam int NW = ece_pkg::NW;

    logic [29:0]   r_z0;
    logic [NW-1:0] r_n0;
    logic [29:0]   r_w [8], r_wb [8], r_q0 [8];
    logic [29:0]   r_za [8], r_zb [8], r_zc [8];
    logic [NW-1:0] r_na [8], r_nb [8], r_nc [8];
    logic [30:0]   r_pc [8];
    logic [30:0]   r_e;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0 <= 30'((64'(i_a[FB-1:0]) * 64'(ece_pkg::LN2_Q30)) >> FB);
            r_n0 <= i_a[ece_pkg::EW-1:FB];
        end
    end

    // one series term per step: divide by k = 8 down to 1
    for (genvar g = 0; g < 8; g++) begin : g_term
        localparam int K = 8 - g;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
        logic [30:0]   p_in;
        logic [29:0]   z_in;
        logic [NW-1:0] n_in;
        logic [33:0]   rem;
        logic [29:0]   q;
        if (g == 0) begin : g_first
            assign p_in = ece_pkg::ONE30;
            assign z_in = r_z0;
            assign n_in = r_n0;
        end else begin : g_rest
            assign p_in = r_pc[g-1];
            assign z_in = r_zc[g-1];
            assign n_in = r_nc[g-1];
        end
        // reciprocal quotient is low by at most one
        always_comb begin
            rem = 34'(r_wb[g]) - 34'(r_q0[g]) * 34'(K);
            q   = (rem >= 34'(K)) ? r_q0[g] + 30'(1) : r_q0[g];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[g]  <= 30'((61'(z_in) * 61'(p_in)) >> 30);
                r_za[g] <= z_in;
                r_na[g] <= n_in;
                r_q0[g] <= 30'((63'(r_w[g]) * 63'(RECIP)) >> 32);
                r_wb[g] <= r_w[g];
                r_zb[g] <= r_za[g];
                r_nb[g] <= r_na[g];
                r_pc[g] <= ece_pkg::ONE30 - 31'(q);
                r_zc[g] <= r_zb[g];
                r_nc[g] <= r_nb[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= r_pc[7] >> r_nc[7];
        end
    end

    assign o_e = r_e;

endmodule

FILE: rtl/core/ece_back.sv
// ece_back: stallable execution pipeline; runs sine, power and exponent
// units side by side and forms the result; uses ece_pkg, ece_sine, ece_expo
module ece_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ece_pkg::t_work         i_work,
    input  logic                   i_work_valid,
    output logic                   o_work_take,
    output logic [ece_pkg::VW-1:0] o_res,
    output logic                   o_res_push,
    input  logic                   i_res_full
);

    localparam int VW  = ece_pkg::VW;
    localparam int SH  = ece_pkg::SH;
    localparam int LAT = ece_pkg::EXP_LAT;
    localparam int SD  = ece_pkg::EXP_LAT - ece_pkg::SIN_LAT;
    localparam int PD  = ece_pkg::EXP_LAT - ece_pkg::POLY_LAT;

    typedef struct packed {
        logic [32:0]   sq;
        logic [VW-1:0] cube;
    } t_poly;

    logic          en;
    logic [LAT:0]  r_vld;
    ece_pkg::t_tag r_tag [LAT];
    logic [30:0]   sin_s, exp_e;
    logic [30:0]   r_sd [SD];
    t_poly         r_pd [PD];
    logic [VW-1:0] r_pa0, r_pa1, r_m;
    logic [32:0]   r_sq0, r_sq1;
    t_poly         r_poly;
    logic [VW-1:0] r_res;
    logic [VW-1:0] n_res;

    // whole pipeline holds while a finished result cannot leave
    assign en          = !(r_vld[LAT] && i_res_full);
    assign o_work_take = en && i_work_valid;
    assign o_res_push  = en && r_vld[LAT];
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:0], i_work_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= '{op: i_work.op, t: i_work.t};
            for (int i = 1; i < LAT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    ece_sine u_sine (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (i_work.sin_x),
        .o_s   (sin_s)
    );

    ece_expo u_expo (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_work.exp_a),
        .o_e   (exp_e)
    );

    // square, rounded square, cube
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa0       <= i_work.poly_a;
            r_sq0       <= 33'((2 * VW)'(i_work.poly_a) * (2 * VW)'(i_work.poly_a));
            r_pa1       <= r_pa0;
            r_sq1       <= r_sq0;
            r_m         <= VW'((34'(r_sq0) + (34'(1) << (ece_pkg::FB - 1))) >> ece_pkg::FB);
            r_poly.sq   <= r_sq1;
            r_poly.cube <= VW'(((2 * VW)'(r_m) * (2 * VW)'(r_pa1)
                               + ((2 * VW)'(1) << (ece_pkg::FB - 1))) >> ece_pkg::FB);
        end
    end

    // align sine and power results with the exponent unit
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= sin_s;
            for (int i = 1; i < SD; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r_pd[0] <= r_poly;
            for (int i = 1; i < PD; i++) begin
                r_pd[i] <= r_pd[i-1];
            end
        end
    end

    logic [31:0] s_w, e_w;
    logic [33:0] sq_w;
    logic [VW-1:0] sin_f, sin_lo, sin_hi, sq_f, sq2_lo, sq2_hi, cube, e_f0, e_f1;

    always_comb begin
        s_w    = 32'(r_sd[SD-1]);
        e_w    = 32'(exp_e);
        sq_w   = 34'(r_pd[PD-1].sq);
        cube   = r_pd[PD-1].cube;
        sin_f  = VW'((s_w + (32'(1) << (SH - 1))) >> SH);
        sin_lo = VW'((32'(ece_pkg::ONE30) - s_w + (32'(1) << SH)) >> (SH + 1));
        sin_hi = VW'((32'(ece_pkg::ONE30) + s_w + (32'(1) << SH)) >> (SH + 1));
        sq_f   = VW'((sq_w + (34'(1) << (ece_pkg::FB - 1))) >> ece_pkg::FB);
        sq2_lo = VW'((sq_w + (34'(1) << (ece_pkg::FB - 2))) >> (ece_pkg::FB - 1));
        sq2_hi = VW'((sq_w + (34'(1) << ece_pkg::FB)) >> (ece_pkg::FB + 1));
        e_f0   = VW'((e_w + (32'(1) << (SH - 1))) >> SH);
        e_f1   = VW'((e_w + (32'(1) << SH)) >> (SH + 1));

        case (r_tag[LAT-1].op)
            ece_pkg::OP_LINEAR:   n_res = r_tag[LAT-1].t;
            ece_pkg::OP_SIN:      n_res = sin_f;
            ece_pkg::OP_SIN_INV:  n_res = ece_pkg::ONE - sin_f;
            ece_pkg::OP_SIN_LO:   n_res = sin_lo;
            ece_pkg::OP_SIN_HI:   n_res = sin_hi;
            ece_pkg::OP_SQ:       n_res = sq_f;
            ece_pkg::OP_SQ_INV:   n_res = ece_pkg::ONE - sq_f;
            ece_pkg::OP_SQ2_LO:   n_res = sq2_lo;
            ece_pkg::OP_SQ2_HI:   n_res = ece_pkg::ONE - sq2_hi;
            ece_pkg::OP_CUBE:     n_res = cube;
            ece_pkg::OP_CUBE_INV: n_res = ece_pkg::ONE - cube;
            ece_pkg::OP_CUBE4:    n_res = VW'({cube, 2'b00});
            ece_pkg::OP_CUBE_HI:  n_res = ece_pkg::ONE - VW'((VW + 1)'(cube) + (VW + 1)'(1) >> 1);
            ece_pkg::OP_EXP:      n_res = e_f0;
            ece_pkg::OP_EXP_INV:  n_res = ece_pkg::ONE - e_f0;
            ece_pkg::OP_EXP_LO:   n_res = e_f1;
            ece_pkg::OP_EXP_HI:   n_res = ece_pkg::ONE - e_f1;
            ece_pkg::OP_ZERO:     n_res = '0;
            ece_pkg::OP_ONE:      n_res = ece_pkg::ONE;
            default:              n_res = r_tag[LAT-1].t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

endmodule

FILE: verif/easing_curve_evaluator_top_tb.sv
// easing_curve_evaluator_top_tb: self-checking testbench for the easing curve evaluator
// depends on ece_pkg and easing_curve_evaluator_top; a bit-exact curve model predicts results
`timescale 1ns / 1ps

module easing_curve_evaluator_top_tb;

    localparam int FB = ece_pkg::FB;
    localparam int SH = ece_pkg::SH;
    localparam int VW = ece_pkg::VW;
    localparam int IW = ece_pkg::IW;

    // bit-exact fixed-point curve model, q30 internals rounded to q1.16
    function automatic logic [63:0] q30_to_val(logic [63:0] v30, int extra);
        int s;
        s = 30 - FB + extra;
        return (v30 + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'(ece_pkg::HALF)) >> FB;
    endfunction

    // sin(pi/2 * x), x in [0, one], odd series in horner form
    function automatic logic [63:0] sine_q30(logic [63:0] x);
        logic [63:0] x30, x2, p;
        x30 = x << SH;
        x2  = (x30 * x30) >> 30;
        p   = 64'(ece_pkg::SIN_C9);
        p   = 64'(ece_pkg::SIN_C7) - ((x2 * p) >> 30);
        p   = 64'(ece_pkg::SIN_C5) - ((x2 * p) >> 30);
        p   = 64'(ece_pkg::SIN_C3) - ((x2 * p) >> 30);
        p   = 64'(ece_pkg::SIN_C1) - ((x2 * p) >> 30);
        p   = (x30 * p) >> 30;
        return (p > 64'(ece_pkg::ONE30)) ? 64'(ece_pkg::ONE30) : p;
    endfunction

    function automatic logic [63:0] sine_val(logic [63:0] x);
        logic [63:0] r;
        r = q30_to_val(sine_q30(x), 0);
        return (r > 64'(ece_pkg::ONE)) ? 64'(ece_pkg::ONE) : r;
    endfunction

    // 2^-a in q30: integer part shifts, fraction via e^-z series
    function automatic logic [63:0] pow2neg_q30(logic [63:0] a);
        logic [63:0] n, f, z, p;
        n = a >> FB;
        f = a & (64'(ece_pkg::ONE) - 1);
        z = ((f << SH) * 64'(ece_pkg::LN2_Q30)) >> 30;
        p = 64'(ece_pkg::ONE30);
        for (int k = 8; k >= 1; k--)
            p = 64'(ece_pkg::ONE30) - (((z * p) >> 30) / k);
        if (n > 30)
            return 0;
        return p >> n;
    endfunction

    function automatic logic [VW-1:0] eased_of(logic [3:0] mode, logic [IW-1:0] raw);
        logic [63:0] t, u, v, one, half, one30, r;
        one   = 64'(ece_pkg::ONE);
        half  = 64'(ece_pkg::HALF);
        one30 = 64'(ece_pkg::ONE30);
        if (raw[IW-1])
            t = 0;
        else
            t = (64'(raw) > one) ? one : 64'(raw);
        u = one - t;
        case (mode)
            ece_pkg::MODE_SINE_IN:    r = one - sine_val(u);
            ece_pkg::MODE_SINE_OUT:   r = sine_val(t);
            ece_pkg::MODE_SINE_INOUT: begin
                if (t <= half)
                    r = q30_to_val(one30 - sine_q30(one - 2 * t), 1);
                else
                    r = q30_to_val(one30 + sine_q30(2 * t - one), 1);
            end
            ece_pkg::MODE_QUAD_IN:    r = fmul(t, t);
            ece_pkg::MODE_QUAD_OUT:   r = one - fmul(u, u);
            ece_pkg::MODE_QUAD_INOUT: begin
                if (t < half) begin
                    r = (2 * t * t + half) >> FB;
                end else begin
                    v = 2 * u;
                    r = one - ((v * v + one) >> (FB + 1));
                end
            end
            ece_pkg::MODE_CUBIC_IN:   r = fmul(fmul(t, t), t);
            ece_pkg::MODE_CUBIC_OUT:  r = one - fmul(fmul(u, u), u);
            ece_pkg::MODE_CUBIC_INOUT: begin
                if (t < half) begin
                    r = 4 * fmul(fmul(t, t), t);
                end else begin
                    v = 2 * u;
                    r = one - ((fmul(fmul(v, v), v) + 1) >> 1);
                end
            end
            ece_pkg::MODE_EXPO_IN:
                r = (t == 0) ? 0 : q30_to_val(pow2neg_q30(10 * u), 0);
            ece_pkg::MODE_EXPO_OUT:
                r = (t == one) ? one : one - q30_to_val(pow2neg_q30(10 * t), 0);
            ece_pkg::MODE_EXPO_INOUT: begin
                if (t == 0)
                    r = 0;
                else if (t == one)
                    r = one;
                else if (t < half)
                    r = q30_to_val(pow2neg_q30(10 * one - 20 * t), 1);
                else
                    r = one - q30_to_val(pow2neg_q30(20 * t - 10 * one), 1);
            end
            default:         r = t;  // linear and unused codes
        endcase
        return r[VW-1:0];
    endfunction

    // expected-value store and checker
    class eased_scoreboard;
        logic [VW-1:0] pending_q[$];
        logic [3:0]    curve;
        int            mismatches;

        function void note_progress(logic [IW-1:0] p);
            pending_q.push_back(eased_of(curve, p));
        endfunction

        function void check_eased(logic [VW-1:0] got);
            logic [VW-1:0] exp_v;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d, nothing pending", got);
                return;
            end
            exp_v = pending_q.pop_front();
            if (got !== exp_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("eased_value mismatch: expected %0d got %0d", exp_v, got);
            end
        endfunction
    endclass

    localparam int LATENCY    = 28;
    localparam int STALL_CAP  = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    logic [IW-1:0] i_progress;
    logic          empty;
    logic          pop;
    logic [VW-1:0] o_eased_value;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [3:0]    i_cfg_data;

    eased_scoreboard sb;
    int  send_idle_pct;   // percent of cycles the sender holds off
    int  recv_idle_pct;   // percent of cycles the receiver holds off
    int  quiet_cycles;

    easing_curve_evaluator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_progress    (i_progress),
        .empty         (empty),
        .pop           (pop),
        .o_eased_value (o_eased_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random pop, check on every accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_eased(o_eased_value);
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_CAP) begin
            $display("easing_curve_evaluator_top_tb: done, errors");
            $finish;
        end
    end

    // one progress transfer, with random gaps before it; push stays high after
    // the transfer so that items can follow back to back
    task automatic send_progress(logic [IW-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_progress <= p;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sb.note_progress(p);
    endtask

    // stop sending, wait until every pending result has come, then let the pipe drain
    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // curve register write, only while the block is idle
    task automatic set_curve(logic [3:0] mode);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.curve = mode;
    endtask

    // progress mostly in range, some out of range on both sides
    function automatic logic [IW-1:0] random_progress();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return IW'($urandom_range(65536));
        else if (sel < 8)
            return IW'($urandom);               // any bit pattern
        else
            return IW'(32768 + $urandom_range(4) - 2);  // around the in-out split
    endfunction

    initial begin
        logic [IW-1:0] corners[$];
        sb = new();
        sb.curve = ece_pkg::MODE_LINEAR;
        send_idle_pct = 19;
        recv_idle_pct = 70;
        push        <= 1'b0;
        i_progress  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: end points, clamps, half and its neighbors, sign bit
        corners = '{IW'(0), IW'(1), IW'(32767), IW'(32768), IW'(32769), IW'(65535),
                    IW'(65536), IW'(65537), IW'(131071), IW'(-1), IW'(-131072),
                    IW'(21845), IW'(43690)};
        // reset curve is linear
        foreach (corners[i]) send_progress(corners[i]);

        // every curve including unused codes and the top extreme 15
        for (int m = 1; m < 16; m++) begin
            set_curve(4'(m));
            foreach (corners[i]) send_progress(corners[i]);
        end

        // random part: three idling phases, curve changes between blocks
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 70 : 0;
            recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 19 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                set_curve(4'($urandom_range(15)));
                for (int n = 0; n < 70; n++)
                    send_progress(random_progress());
                // hold off until all results are back once per phase
                if (blk == 3)
                    drain_results();
            end
        end
        set_curve(ece_pkg::MODE_LINEAR);

        drain_results();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("easing_curve_evaluator_top_tb: done, clean");
        else
            $display("easing_curve_evaluator_top_tb: done, errors");
        $finish;
    end

endmodule

FILE: easing_curve_evaluator_top.f
rtl/core/ece_pkg.sv
rtl/core/ece_queue.sv
rtl/core/ece_front.sv
rtl/core/ece_sine.sv
rtl/core/ece_expo.sv
rtl/core/ece_back.sv
rtl/core/easing_curve_evaluator_top.sv
verif/easing_curve_evaluator_top_tb.sv
